// ===== rtl/rthsv_pkg.sv =====
// shared types and constants for the rgb to hsv pixel converter
package rthsv_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned QuoW  = 8;
  localparam int unsigned NumW  = 17;
  localparam int unsigned NumCells = QuoW;

  localparam logic [ChanW-1:0] HueBaseRedWrap = 8'd180;
  localparam logic [ChanW-1:0] HueBaseGreen   = 8'd60;
  localparam logic [ChanW-1:0] HueBaseBlue    = 8'd120;
  localparam logic [ChanW-1:0] HueBaseRed     = 8'd0;
  localparam logic [NumW-1:0]  HueStep        = 17'd30;
  localparam logic [NumW-1:0]  SatScale2      = 17'd510;
  localparam logic [NumW-1:0]  SafeDen        = 17'd256;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic             last_pixel;
  } rgb_t;

  typedef struct packed {
    logic [ChanW-1:0] hue_out;
    logic [ChanW-1:0] sat_out;
    logic [ChanW-1:0] value_out;
    logic             last_out;
  } hsv_t;

  typedef struct packed {
    logic [NumW-1:0]  hue_rem;
    logic [NumW-1:0]  hue_den;
    logic [QuoW-1:0]  hue_q;
    logic [NumW-1:0]  sat_rem;
    logic [NumW-1:0]  sat_den;
    logic [QuoW-1:0]  sat_q;
    logic [ChanW-1:0] value;
    logic             last;
  } div_cell_t;

endpackage

// ===== rtl/rgb_to_hsv_pixel.sv =====
// top level of the rgb to hsv pixel converter: front stage and divider cell row
//
//   port       dir  type   transaction
//   start      in   1      pixel taken when start high and busy low
//   busy       out  1      always low, a pixel may enter every cycle
//   pixel_i    in   rgb_t  red, green, blue, last marker
//   done_o     out  1      result strobe, one cycle per result
//   result_o   out  hsv_t  hue, saturation, value, last marker
//
// one pixel per clock sustained; from acceptance to done_o a pixel passes through
// one front stage (max, min, dividends) and one cell per quotient bit (8 cells).
// reset clears all valid flags; results in flight are dropped.
// the receiver cannot stall, so nothing holds the row back.
module rgb_to_hsv_pixel (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rthsv_pkg::rgb_t pixel_i,
  output logic            done_o,
  output rthsv_pkg::hsv_t result_o
);
  import rthsv_pkg::*;

  logic      valid_w [NumCells+1];
  div_cell_t data_w  [NumCells+1];

  assign busy = 1'b0;

  rthsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .pixel_i (pixel_i),
    .valid_o (valid_w[0]),
    .data_o  (data_w[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rthsv_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[i]),
      .data_i  (data_w[i]),
      .valid_o (valid_w[i+1]),
      .data_o  (data_w[i+1])
    );
  end

  assign done_o   = valid_w[NumCells];
  assign result_o = {data_w[NumCells].hue_q, data_w[NumCells].sat_q,
                     data_w[NumCells].value, data_w[NumCells].last};

  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##9 done_o)
    else $error("accepted pixel did not produce a result after 9 cycles");

  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 9))
    else $error("result without a matching accepted pixel");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.hue_out <= 8'd180))
    else $error("hue above 180");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.value_out == '0) |->
      (result_o.sat_out == '0 && result_o.hue_out == '0))
    else $error("black pixel with nonzero hue or saturation");

endmodule

// ===== rtl/rthsv_front.sv =====
// input stage: max, min, sector and both dividends and divisors
module rthsv_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rthsv_pkg::rgb_t    pixel_i,
  output logic               valid_o,
  output rthsv_pkg::div_cell_t data_o
);
  import rthsv_pkg::*;

  logic [ChanW-1:0]    r, g, b, mx, mn, d, base;
  logic signed [8:0]   delta;
  logic signed [14:0]  delta30;
  logic [15:0]         base_d;
  logic signed [17:0]  n_s;
  logic [NumW-1:0]     hue_num, sat_num;
  logic                valid_q;
  div_cell_t           data_d, data_q;

  always_comb begin
    r = pixel_i.red_in;
    g = pixel_i.green_in;
    b = pixel_i.blue_in;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;

    // sector of the largest channel, red wins ties, then green
    if (mx == r) begin
      base  = (g < b) ? HueBaseRedWrap : HueBaseRed;
      delta = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (mx == g) begin
      base  = HueBaseGreen;
      delta = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      base  = HueBaseBlue;
      delta = $signed({1'b0, r}) - $signed({1'b0, g});
    end

    base_d  = 16'(base) * 16'(d);
    delta30 = 15'(delta) * $signed(15'(HueStep));
    n_s     = $signed({2'b00, base_d}) + 18'(delta30);
    hue_num = {n_s[15:0], 1'b0} + 17'(d);
    sat_num = 17'(d) * SatScale2 + 17'(mx);

    data_d.hue_q   = '0;
    data_d.sat_q   = '0;
    data_d.value   = mx;
    data_d.last    = pixel_i.last_pixel;
    data_d.sat_rem = sat_num;
    // gray or black pixel: zero dividend over a safe divisor gives zero
    if (d == '0) begin
      data_d.hue_rem = '0;
      data_d.hue_den = SafeDen;
    end else begin
      data_d.hue_rem = hue_num;
      data_d.hue_den = {1'b0, d, 8'b0};
    end
    if (mx == '0) begin
      data_d.sat_den = SafeDen;
    end else begin
      data_d.sat_den = {1'b0, mx, 8'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/rthsv_div_cell.sv =====
// one restoring divider cell: one quotient bit of hue and saturation
module rthsv_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rthsv_pkg::div_cell_t data_i,
  output logic                 valid_o,
  output rthsv_pkg::div_cell_t data_o
);
  import rthsv_pkg::*;

  logic      hue_ge, sat_ge, valid_q;
  div_cell_t data_d, data_q;

  always_comb begin
    hue_ge = data_i.hue_rem >= data_i.hue_den;
    sat_ge = data_i.sat_rem >= data_i.sat_den;
    data_d = data_i;
    data_d.hue_rem = hue_ge ? data_i.hue_rem - data_i.hue_den : data_i.hue_rem;
    data_d.sat_rem = sat_ge ? data_i.sat_rem - data_i.sat_den : data_i.sat_rem;
    data_d.hue_den = data_i.hue_den >> 1;
    data_d.sat_den = data_i.sat_den >> 1;
    data_d.hue_q   = {data_i.hue_q[QuoW-2:0], hue_ge};
    data_d.sat_q   = {data_i.sat_q[QuoW-2:0], sat_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
